@@ rtl/mdc_pkg.sv @@
// ----------------------------------------------------------------------------
// mdc_pkg
// types, constants and register codes shared by the duty controller files
// ----------------------------------------------------------------------------
package mdc_pkg;

    localparam int MEAS_W = 16;
    localparam int DUTY_W = 9;
    localparam int POWER_W = 2 * MEAS_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // duty limits and steps in quarter percent
    localparam logic [DUTY_W-1:0] DUTY_MAX_Q = 9'd380;
    localparam logic [DUTY_W-1:0] DUTY_STEP_Q = 9'd3;
    localparam logic [DUTY_W-1:0] DUTY_MPPT_START_Q =
        (9'd40 > DUTY_MAX_Q) ? DUTY_MAX_Q : 9'd40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IN_CURRENT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_VOLTAGE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CURRENT_LIMIT = 2'd2;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] IN_CURRENT_LIMIT_RST = 16'd3000;
    localparam logic [CFG_DATA_W-1:0] OUT_VOLTAGE_LIMIT_RST = 16'd4200;
    localparam logic [CFG_DATA_W-1:0] OUT_CURRENT_LIMIT_RST = 16'd200;

    typedef struct packed {
        logic [MEAS_W-1:0] in_current_limit_ma;
        logic [MEAS_W-1:0] out_voltage_limit_mv;
        logic [MEAS_W-1:0] out_current_limit_ma;
    } t_cfg;

    typedef struct packed {
        logic [MEAS_W-1:0] solar_mv;
        logic [MEAS_W-1:0] sink_mv;
        logic [MEAS_W-1:0] conv_in_mv;
        logic [MEAS_W-1:0] conv_in_ma;
        logic [MEAS_W-1:0] batt_mv;
        logic [MEAS_W-1:0] batt_ma;
    } t_tick;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_q;
        logic              mppt_active;
    } t_result;

    // handshake between the input register and the result register
    typedef struct packed {
        logic advance;
    } t_flow;

endpackage

@@ rtl/mdc_tick_if.sv @@
// ----------------------------------------------------------------------------
// mdc_tick_if
// measurement channel, one transaction per control tick
// ----------------------------------------------------------------------------
interface mdc_tick_if;
    import mdc_pkg::*;

    logic              valid;
    logic              ready;
    logic [MEAS_W-1:0] solar_mv;
    logic [MEAS_W-1:0] sink_mv;
    logic [MEAS_W-1:0] conv_in_mv;
    logic [MEAS_W-1:0] conv_in_ma;
    logic [MEAS_W-1:0] batt_mv;
    logic [MEAS_W-1:0] batt_ma;

    modport source (
        output valid, solar_mv, sink_mv, conv_in_mv, conv_in_ma, batt_mv, batt_ma,
        input  ready
    );

    modport sink (
        input  valid, solar_mv, sink_mv, conv_in_mv, conv_in_ma, batt_mv, batt_ma,
        output ready
    );

endinterface

@@ rtl/mdc_duty_if.sv @@
// ----------------------------------------------------------------------------
// mdc_duty_if
// duty result channel, one transaction per control tick
// ----------------------------------------------------------------------------
interface mdc_duty_if;
    import mdc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_q;
    logic              mppt_active;

    modport source (
        output valid, duty_q, mppt_active,
        input  ready
    );

    modport sink (
        input  valid, duty_q, mppt_active,
        output ready
    );

endinterface

@@ rtl/mdc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mdc_cfg_regs
// limit registers for normal mode, written through a plain write port
// ----------------------------------------------------------------------------
module mdc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mdc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mdc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output mdc_pkg::t_cfg                   o_cfg
);
    import mdc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IN_CURRENT_LIMIT:  n_cfg.in_current_limit_ma = i_cfg_data;
                CFG_OUT_VOLTAGE_LIMIT: n_cfg.out_voltage_limit_mv = i_cfg_data;
                CFG_OUT_CURRENT_LIMIT: n_cfg.out_current_limit_ma = i_cfg_data;
                default: ; // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_current_limit_ma <= IN_CURRENT_LIMIT_RST;
            r_cfg.out_voltage_limit_mv <= OUT_VOLTAGE_LIMIT_RST;
            r_cfg.out_current_limit_ma <= OUT_CURRENT_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/mdc_in_reg.sv @@
// ----------------------------------------------------------------------------
// mdc_in_reg
// input register, holds one tick until the step logic takes it
// ----------------------------------------------------------------------------
module mdc_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mdc_tick_if.sink         i_in,
    input  logic             i_advance,
    output logic             o_tick_valid,
    output mdc_pkg::t_tick   o_tick
);
    import mdc_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_tick r_tick;
    logic  accept;

    assign i_in.ready = !r_valid || i_advance;
    assign accept = i_in.valid && i_in.ready;
    assign n_valid = accept || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tick.solar_mv <= i_in.solar_mv;
            r_tick.sink_mv <= i_in.sink_mv;
            r_tick.conv_in_mv <= i_in.conv_in_mv;
            r_tick.conv_in_ma <= i_in.conv_in_ma;
            r_tick.batt_mv <= i_in.batt_mv;
            r_tick.batt_ma <= i_in.batt_ma;
        end
    end

    assign o_tick_valid = r_valid;
    assign o_tick = r_tick;

endmodule

@@ rtl/mdc_step.sv @@
// ----------------------------------------------------------------------------
// mdc_step
// one control tick: mode choice, reload, perturb-and-observe or limit step
// ----------------------------------------------------------------------------
module mdc_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  mdc_pkg::t_tick   i_tick,
    input  mdc_pkg::t_cfg    i_cfg,
    output mdc_pkg::t_result o_result
);
    import mdc_pkg::*;

    logic [DUTY_W-1:0]  r_duty;
    logic               r_mode;
    logic [POWER_W-1:0] r_prev_power;
    logic [DUTY_W-1:0]  r_prev_duty;

    logic               want_mppt;
    logic [DUTY_W-1:0]  duty_start;
    logic [POWER_W-1:0] power;
    logic               rising;
    logic               step_up;
    logic [DUTY_W:0]    up_sum;
    logic [DUTY_W-1:0]  n_duty;

    always_comb begin
        want_mppt = i_tick.solar_mv > i_tick.sink_mv;

        // reload on mode change
        duty_start = r_duty;
        if (want_mppt != r_mode) begin
            duty_start = want_mppt ? DUTY_MPPT_START_Q : '0;
        end

        power = POWER_W'(i_tick.conv_in_mv) * POWER_W'(i_tick.conv_in_ma);
        rising = duty_start > r_prev_duty;

        if (want_mppt) begin
            // keep direction while power grows, reverse otherwise
            step_up = (power > r_prev_power) == rising;
        end else begin
            step_up = (i_tick.conv_in_ma < i_cfg.in_current_limit_ma)
                   && (i_tick.batt_mv < i_cfg.out_voltage_limit_mv)
                   && (i_tick.batt_ma < i_cfg.out_current_limit_ma);
        end

        up_sum = {1'b0, duty_start} + {1'b0, DUTY_STEP_Q};

        if (step_up) begin
            if (duty_start < DUTY_MAX_Q) begin
                n_duty = (up_sum > {1'b0, DUTY_MAX_Q}) ? DUTY_MAX_Q : up_sum[DUTY_W-1:0];
            end else begin
                n_duty = duty_start;
            end
        end else begin
            n_duty = (duty_start >= DUTY_STEP_Q) ? duty_start - DUTY_STEP_Q : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty <= '0;
            r_mode <= 1'b0;
            r_prev_power <= '0;
            r_prev_duty <= '0;
        end else if (i_advance) begin
            r_duty <= n_duty;
            r_mode <= want_mppt;
            if (want_mppt) begin
                r_prev_power <= power;
                r_prev_duty <= n_duty;
            end
        end
    end

    assign o_result.duty_q = n_duty;
    assign o_result.mppt_active = want_mppt;

endmodule

@@ rtl/mdc_out_reg.sv @@
// ----------------------------------------------------------------------------
// mdc_out_reg
// result register, holds a finished duty until the receiver takes it
// ----------------------------------------------------------------------------
module mdc_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tick_valid,
    input  mdc_pkg::t_result i_result,
    output mdc_pkg::t_flow   o_flow,
    mdc_duty_if.source       o_out
);
    import mdc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;
    logic    advance;

    assign advance = i_tick_valid && (!r_valid || o_out.ready);
    assign n_valid = advance || (r_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= i_result;
        end
    end

    assign o_flow.advance = advance;

    assign o_out.valid = r_valid;
    assign o_out.duty_q = r_result.duty_q;
    assign o_out.mppt_active = r_result.mppt_active;

endmodule

@@ rtl/mppt_dcdc_duty_controller_top.sv @@
// ----------------------------------------------------------------------------
// mppt_dcdc_duty_controller_top
// per-tick pwm duty controller for a solar charging dc-dc converter
// ----------------------------------------------------------------------------
// usage
//   i_in carries one transaction per control tick: solar, sink, converter
//   input and battery voltages and currents. o_out returns one transaction
//   per tick with the new duty in quarter percent and the mode flag.
//   mppt mode runs perturb-and-observe on conv_in_mv * conv_in_ma; normal
//   mode steps duty up while all three limits are unmet, else down.
//   the limits are written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no tick is in flight; indexes past the last register are ignored.
// timing
//   a tick accepted from i_in is registered, stepped into the result
//   register and shown on o_out from then on. one tick per cycle sustained
//   while o_out is ready; the cycle is set by the 16 x 16 power product,
//   its compare with the previous power and the duty step.
// reset and stalls
//   synchronous active-low reset clears duty, mode (normal), previous power
//   and previous duty, empties both registers and reloads the limits.
//   while o_out is stalled the result holds; one more tick waits in the
//   input register, after which i_in.ready drops.
// ----------------------------------------------------------------------------
module mppt_dcdc_duty_controller_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mdc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mdc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mdc_tick_if.sink                        i_in,
    mdc_duty_if.source                      o_out
);
    import mdc_pkg::*;

    t_cfg    cfg;
    t_tick   tick;
    logic    tick_valid;
    t_result result;
    t_flow   flow;

    // normal mode limits
    mdc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input register, refills in the cycle its tick moves on
    mdc_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_advance    (flow.advance),
        .o_tick_valid (tick_valid),
        .o_tick       (tick)
    );

    // controller state and the step itself, state moves with each tick
    mdc_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(flow.advance),
        .i_tick   (tick),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // result register, decides when a tick may advance
    mdc_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_valid (tick_valid),
        .i_result     (result),
        .o_flow       (flow),
        .o_out        (o_out)
    );

endmodule
